// ----- src/epmm_pkg.sv -----
package epmm_pkg;

    // queue depth default
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // field widths
    localparam int OP_W      = 3;
    localparam int EVENT_W   = 4;
    localparam int TIMEOUT_W = 16;
    localparam int MODE_W    = 3;
    localparam int ACTION_W  = 3;
    localparam int CMD_W     = 2;
    localparam int KIND_W    = 2;
    localparam int COAST_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RESTART_DELAY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COAST_TICKS       = 1'd1;

    // register reset values
    localparam logic [TIMEOUT_W-1:0] MIN_RESTART_DELAY_RESET = 16'd10;
    localparam logic [COAST_W-1:0]   COAST_TICKS_RESET       = 32'd6000;

    // local shutdown and sleep delays
    localparam logic [TIMEOUT_W-1:0] LOCAL_MIN_DELAY  = 16'd10;
    localparam logic [TIMEOUT_W-1:0] SHUTDOWN_REQUEST = 16'd10;
    localparam logic [TIMEOUT_W-1:0] SLEEP_REQUEST    = 16'd1;
    localparam logic [TIMEOUT_W-1:0] SHUTDOWN_LOAD =
        (SHUTDOWN_REQUEST < LOCAL_MIN_DELAY) ? LOCAL_MIN_DELAY : SHUTDOWN_REQUEST;
    localparam logic [TIMEOUT_W-1:0] SLEEP_LOAD =
        (SLEEP_REQUEST < LOCAL_MIN_DELAY) ? LOCAL_MIN_DELAY : SLEEP_REQUEST;

    // operations
    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_POST       = 3'd1;
    localparam logic [OP_W-1:0] OP_REQ_RESET  = 3'd2;
    localparam logic [OP_W-1:0] OP_REQ_BOOT   = 3'd3;
    localparam logic [OP_W-1:0] OP_REQ_TESTER = 3'd4;
    localparam logic [OP_W-1:0] OP_FORCE      = 3'd5;

    // ecu modes
    localparam logic [MODE_W-1:0] M_OFF     = 3'd0;
    localparam logic [MODE_W-1:0] M_WAKE    = 3'd1;
    localparam logic [MODE_W-1:0] M_MONITOR = 3'd2;
    localparam logic [MODE_W-1:0] M_QUIET   = 3'd3;
    localparam logic [MODE_W-1:0] M_FULL    = 3'd4;

    // events
    localparam logic [EVENT_W-1:0] EV_NONE      = 4'd0;
    localparam logic [EVENT_W-1:0] EV_IGN_ON    = 4'd1;
    localparam logic [EVENT_W-1:0] EV_IGN_OFF   = 4'd2;
    localparam logic [EVENT_W-1:0] EV_COMM_TO   = 4'd3;
    localparam logic [EVENT_W-1:0] EV_COAST_TO  = 4'd4;
    localparam logic [EVENT_W-1:0] EV_STOP      = 4'd5;
    localparam logic [EVENT_W-1:0] EV_DRIVE     = 4'd6;
    localparam logic [EVENT_W-1:0] EV_CAN_WAKE  = 4'd7;
    localparam logic [EVENT_W-1:0] EV_DEEP_STOP = 4'd8;
    localparam logic [EVENT_W-1:0] EV_SHUTDOWN  = 4'd9;

    // final actions
    localparam logic [ACTION_W-1:0] FA_NONE       = 3'd0;
    localparam logic [ACTION_W-1:0] FA_SHUTDOWN   = 3'd1;
    localparam logic [ACTION_W-1:0] FA_SLEEP      = 3'd2;
    localparam logic [ACTION_W-1:0] FA_RESET      = 3'd3;
    localparam logic [ACTION_W-1:0] FA_BOOTLOADER = 3'd4;
    localparam logic [ACTION_W-1:0] FA_TESTER     = 3'd5;

    // start/stop command codes
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_OVER  = 2'd3;

    // restart kinds
    localparam logic [KIND_W-1:0] KIND_RESET      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BOOTLOADER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TESTER     = 2'd2;

    // result item, last member in the lowest bits
    typedef struct packed {
        logic                sleep_target;
        logic [KIND_W-1:0]   reset_kind;
        logic                event_dropped;
        logic                wake_transceiver;
        logic [CMD_W-1:0]    coast_cmd;
        logic [CMD_W-1:0]    diag_cycle_cmd;
        logic [CMD_W-1:0]    comm_timeout_cmd;
        logic                comm_shutdown;
        logic [CMD_W-1:0]    tx_group_cmd;
        logic [ACTION_W-1:0] final_action;
        logic [MODE_W-1:0]   ecu_mode;
    } result_t;

endpackage

// ----- src/ecu_power_mode_manager_top.sv -----
// channel   | signals                      | contents
// ----------+------------------------------+------------------------------------------
// s (in)    | s_tvalid s_tready s_tdata    | one request: operation, event, timeout,
//           | s_tuser                      | forced mode
// m (out)   | m_tvalid m_tready m_tdata    | one result per request: mode, commands,
//           |                              | stored restart kind and sleep target
// cfg       | cfg_we cfg_index cfg_data    | min_restart_delay, coast_ticks writes
//
// a request passes from acceptance into the input register, then through the state
// update logic into the result register
// sustained rate is one request per cycle while m_tready is high; timers, event queue
// and mode transition all update in the cycle a request leaves the input register
// reset clears all control state at once: mode off, queue empty, timers idle,
// registers at their reset values; no clearing pass
// a stall on the result side holds the result register; one more request waits in
// the input register, then s_tready drops until the result is taken
module ecu_power_mode_manager_top #(
    parameter int QUEUE_DEPTH = epmm_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [3:0] event_code, [19:4] timeout, [22:20] new_ecu_mode, [23] zero
    input  logic [epmm_pkg::IN_DATA_W-1:0]    s_tdata,
    // [2:0] operation
    input  logic [epmm_pkg::OP_W-1:0]         s_tuser,
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] ecu_mode, [5:3] final_action, [7:6] tx_group_cmd, [8] comm_shutdown,
    // [10:9] comm_timeout_cmd, [12:11] diag_cycle_cmd, [14:13] coast_cmd,
    // [15] wake_transceiver, [16] event_dropped, [18:17] reset_kind,
    // [19] sleep_target, [23:20] zero
    output logic [epmm_pkg::OUT_DATA_W-1:0]   m_tdata,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [epmm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [epmm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int RES_W = $bits(epmm_pkg::result_t);

    // configuration registers
    logic [epmm_pkg::TIMEOUT_W-1:0] min_delay_reg;
    logic [epmm_pkg::COAST_W-1:0]   coast_ticks_reg;

    // input register
    logic                           in_valid_reg;
    logic [epmm_pkg::OP_W-1:0]      in_op_reg;
    logic [epmm_pkg::EVENT_W-1:0]   in_event_reg;
    logic [epmm_pkg::TIMEOUT_W-1:0] in_timeout_reg;
    logic [epmm_pkg::MODE_W-1:0]    in_fmode_reg;

    // block state
    logic [epmm_pkg::MODE_W-1:0]    mode_reg, mode_next;
    logic [epmm_pkg::EVENT_W-1:0]   queue_reg [QUEUE_DEPTH];
    logic [epmm_pkg::EVENT_W-1:0]   queue_next [QUEUE_DEPTH];
    logic [epmm_pkg::TIMEOUT_W-1:0] shutdown_count_reg, shutdown_count_next;
    logic [epmm_pkg::TIMEOUT_W-1:0] sleep_count_reg, sleep_count_next;
    logic [epmm_pkg::TIMEOUT_W-1:0] reset_count_reg, reset_count_next;
    logic [epmm_pkg::TIMEOUT_W-1:0] boot_count_reg, boot_count_next;
    logic [epmm_pkg::TIMEOUT_W-1:0] tester_count_reg, tester_count_next;
    logic [epmm_pkg::COAST_W-1:0]   coast_count_reg, coast_count_next;
    logic [epmm_pkg::KIND_W-1:0]    restart_kind_reg, restart_kind_next;
    logic                           sleep_flag_reg, sleep_flag_next;

    // result register
    logic                           out_valid_reg;
    epmm_pkg::result_t              result_reg, result_next;

    logic                           advance;
    logic [epmm_pkg::TIMEOUT_W-1:0] restart_load;
    logic                           queue_gap;

    // the input register moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(epmm_pkg::OUT_DATA_W - RES_W){1'b0}}, result_reg};

    // restart timers never load below the configured floor
    assign restart_load = (in_timeout_reg < min_delay_reg) ? min_delay_reg : in_timeout_reg;

    always_comb
    begin
        logic [epmm_pkg::EVENT_W-1:0] q_work [QUEUE_DEPTH];
        logic                         push_req;
        logic [epmm_pkg::EVENT_W-1:0] push_ev;
        logic                         pop_req;
        logic                         found;
        logic [epmm_pkg::EVENT_W-1:0] ev;

        mode_next           = mode_reg;
        shutdown_count_next = shutdown_count_reg;
        sleep_count_next    = sleep_count_reg;
        reset_count_next    = reset_count_reg;
        boot_count_next     = boot_count_reg;
        tester_count_next   = tester_count_reg;
        coast_count_next    = coast_count_reg;
        restart_kind_next   = restart_kind_reg;
        sleep_flag_next     = sleep_flag_reg;
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            q_work[k] = queue_reg[k];
        end
        push_req = 1'b0;
        push_ev  = epmm_pkg::EV_NONE;
        pop_req  = 1'b0;
        found    = 1'b0;
        ev       = epmm_pkg::EV_NONE;
        result_next = '0;

        // timers and requests
        case (in_op_reg)
            epmm_pkg::OP_TICK:
            begin
                pop_req = 1'b1;
                // only the highest-priority running timer counts
                if (shutdown_count_reg != '0)
                begin
                    shutdown_count_next = shutdown_count_reg - 1'b1;
                    if (shutdown_count_reg == 16'd1)
                    begin
                        sleep_flag_next = 1'b0;
                        result_next.final_action = epmm_pkg::FA_SHUTDOWN;
                    end
                end
                else if (sleep_count_reg != '0)
                begin
                    sleep_count_next = sleep_count_reg - 1'b1;
                    if (sleep_count_reg == 16'd1)
                    begin
                        sleep_flag_next = 1'b1;
                        result_next.final_action = epmm_pkg::FA_SLEEP;
                    end
                end
                else if (reset_count_reg != '0)
                begin
                    reset_count_next = reset_count_reg - 1'b1;
                    if (reset_count_reg == 16'd1)
                    begin
                        restart_kind_next = epmm_pkg::KIND_RESET;
                        result_next.final_action = epmm_pkg::FA_RESET;
                    end
                end
                else if (boot_count_reg != '0)
                begin
                    boot_count_next = boot_count_reg - 1'b1;
                    if (boot_count_reg == 16'd1)
                    begin
                        restart_kind_next = epmm_pkg::KIND_BOOTLOADER;
                        result_next.final_action = epmm_pkg::FA_BOOTLOADER;
                    end
                end
                else if (tester_count_reg != '0)
                begin
                    tester_count_next = tester_count_reg - 1'b1;
                    if (tester_count_reg == 16'd1)
                    begin
                        restart_kind_next = epmm_pkg::KIND_TESTER;
                        result_next.final_action = epmm_pkg::FA_TESTER;
                    end
                end
                else if (coast_count_reg != '0)
                begin
                    coast_count_next = coast_count_reg - 1'b1;
                    if (coast_count_reg == 32'd1)
                    begin
                        push_req = 1'b1;
                        push_ev  = epmm_pkg::EV_COAST_TO;
                    end
                end
            end
            epmm_pkg::OP_POST:
            begin
                if (in_event_reg != epmm_pkg::EV_NONE && in_event_reg <= epmm_pkg::EV_SHUTDOWN)
                begin
                    push_req = 1'b1;
                    push_ev  = in_event_reg;
                end
            end
            epmm_pkg::OP_REQ_RESET:
            begin
                reset_count_next = restart_load;
            end
            epmm_pkg::OP_REQ_BOOT:
            begin
                boot_count_next = restart_load;
            end
            epmm_pkg::OP_REQ_TESTER:
            begin
                tester_count_next = restart_load;
            end
            epmm_pkg::OP_FORCE:
            begin
                if (in_fmode_reg <= epmm_pkg::M_FULL)
                begin
                    mode_next = in_fmode_reg;
                end
            end
            default:
            begin
            end
        endcase

        // push into the first empty slot
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            if (!found && q_work[k] == epmm_pkg::EV_NONE)
            begin
                found = 1'b1;
                if (push_req)
                begin
                    q_work[k] = push_ev;
                end
            end
        end
        result_next.event_dropped = push_req && !found;

        // pop the head on a tick
        if (pop_req)
        begin
            ev = q_work[0];
            if (ev != epmm_pkg::EV_NONE)
            begin
                for (int k = 0; k < QUEUE_DEPTH - 1; k++)
                begin
                    q_work[k] = q_work[k + 1];
                end
                q_work[QUEUE_DEPTH - 1] = epmm_pkg::EV_NONE;
            end
        end

        // mode transitions
        if (ev != epmm_pkg::EV_NONE)
        begin
            case (mode_reg)
                epmm_pkg::M_QUIET:
                begin
                    if (ev == epmm_pkg::EV_IGN_ON)
                    begin
                        coast_count_next = '0;
                        result_next.tx_group_cmd     = epmm_pkg::CMD_START;
                        result_next.comm_timeout_cmd = epmm_pkg::CMD_START;
                        result_next.diag_cycle_cmd   = epmm_pkg::CMD_START;
                        mode_next = epmm_pkg::M_FULL;
                    end
                    else if (ev == epmm_pkg::EV_COMM_TO)
                    begin
                        result_next.comm_timeout_cmd = epmm_pkg::CMD_STOP;
                        mode_next = epmm_pkg::M_MONITOR;
                    end
                    else if (ev == epmm_pkg::EV_COAST_TO)
                    begin
                        result_next.coast_cmd = epmm_pkg::CMD_OVER;
                    end
                end
                epmm_pkg::M_FULL:
                begin
                    if (ev == epmm_pkg::EV_IGN_OFF)
                    begin
                        coast_count_next = coast_ticks_reg;
                        result_next.coast_cmd      = epmm_pkg::CMD_START;
                        result_next.tx_group_cmd   = epmm_pkg::CMD_STOP;
                        result_next.diag_cycle_cmd = epmm_pkg::CMD_STOP;
                        mode_next = epmm_pkg::M_QUIET;
                    end
                    else if (ev == epmm_pkg::EV_COMM_TO)
                    begin
                        result_next.coast_cmd        = epmm_pkg::CMD_OVER;
                        result_next.tx_group_cmd     = epmm_pkg::CMD_STOP;
                        result_next.diag_cycle_cmd   = epmm_pkg::CMD_STOP;
                        result_next.comm_timeout_cmd = epmm_pkg::CMD_START;
                        mode_next = epmm_pkg::M_QUIET;
                    end
                    else if (ev == epmm_pkg::EV_STOP)
                    begin
                        result_next.coast_cmd = epmm_pkg::CMD_START;
                    end
                    else if (ev == epmm_pkg::EV_DRIVE)
                    begin
                        result_next.coast_cmd = epmm_pkg::CMD_STOP;
                    end
                end
                epmm_pkg::M_WAKE, epmm_pkg::M_MONITOR:
                begin
                    if (ev == epmm_pkg::EV_CAN_WAKE)
                    begin
                        result_next.wake_transceiver = (mode_reg == epmm_pkg::M_WAKE);
                        result_next.comm_timeout_cmd = epmm_pkg::CMD_START;
                        mode_next = epmm_pkg::M_QUIET;
                    end
                    else if (ev == epmm_pkg::EV_DEEP_STOP)
                    begin
                        result_next.comm_shutdown = 1'b1;
                        sleep_count_next = epmm_pkg::SLEEP_LOAD;
                        mode_next = epmm_pkg::M_OFF;
                    end
                    else if (ev == epmm_pkg::EV_SHUTDOWN)
                    begin
                        result_next.comm_shutdown = 1'b1;
                        shutdown_count_next = epmm_pkg::SHUTDOWN_LOAD;
                        mode_next = epmm_pkg::M_OFF;
                    end
                    else if (ev == epmm_pkg::EV_COAST_TO && mode_reg == epmm_pkg::M_MONITOR)
                    begin
                        result_next.coast_cmd = epmm_pkg::CMD_OVER;
                    end
                end
                default:
                begin
                end
            endcase
        end

        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            queue_next[k] = q_work[k];
        end
        result_next.ecu_mode     = mode_next;
        result_next.reset_kind   = restart_kind_next;
        result_next.sleep_target = sleep_flag_next;
    end

    // state, control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_delay_reg      <= epmm_pkg::MIN_RESTART_DELAY_RESET;
            coast_ticks_reg    <= epmm_pkg::COAST_TICKS_RESET;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            mode_reg           <= epmm_pkg::M_OFF;
            shutdown_count_reg <= '0;
            sleep_count_reg    <= '0;
            reset_count_reg    <= '0;
            boot_count_reg     <= '0;
            tester_count_reg   <= '0;
            coast_count_reg    <= '0;
            restart_kind_reg   <= epmm_pkg::KIND_RESET;
            sleep_flag_reg     <= 1'b0;
            for (int k = 0; k < QUEUE_DEPTH; k++)
            begin
                queue_reg[k] <= epmm_pkg::EV_NONE;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    epmm_pkg::REG_MIN_RESTART_DELAY:
                        min_delay_reg <= cfg_data[epmm_pkg::TIMEOUT_W-1:0];
                    epmm_pkg::REG_COAST_TICKS:
                        coast_ticks_reg <= cfg_data[epmm_pkg::COAST_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                mode_reg           <= mode_next;
                shutdown_count_reg <= shutdown_count_next;
                sleep_count_reg    <= sleep_count_next;
                reset_count_reg    <= reset_count_next;
                boot_count_reg     <= boot_count_next;
                tester_count_reg   <= tester_count_next;
                coast_count_reg    <= coast_count_next;
                restart_kind_reg   <= restart_kind_next;
                sleep_flag_reg     <= sleep_flag_next;
                for (int k = 0; k < QUEUE_DEPTH; k++)
                begin
                    queue_reg[k] <= queue_next[k];
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg      <= s_tuser;
            in_event_reg   <= s_tdata[epmm_pkg::EVENT_W-1:0];
            in_timeout_reg <= s_tdata[epmm_pkg::EVENT_W +: epmm_pkg::TIMEOUT_W];
            in_fmode_reg   <= s_tdata[epmm_pkg::EVENT_W + epmm_pkg::TIMEOUT_W +: epmm_pkg::MODE_W];
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // queued events stay packed toward the head
    always_comb
    begin
        queue_gap = 1'b0;
        for (int k = 0; k < QUEUE_DEPTH - 1; k++)
        begin
            if (queue_reg[k] == epmm_pkg::EV_NONE && queue_reg[k + 1] != epmm_pkg::EV_NONE)
            begin
                queue_gap = 1'b1;
            end
        end
    end

    a_queue_packed: assert property (@(posedge clk) disable iff (!rst_n) !queue_gap)
        else $error("event queue has a hole");

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= epmm_pkg::M_FULL)
        else $error("current mode out of range");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed request gave no result");

    a_quiet_non_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_op_reg != epmm_pkg::OP_TICK) |=>
            (result_reg.final_action == epmm_pkg::FA_NONE
             && result_reg.tx_group_cmd == epmm_pkg::CMD_NONE
             && result_reg.coast_cmd == epmm_pkg::CMD_NONE))
        else $error("command issued outside a tick");

endmodule
